FILE: src/double_ended_queue_with_search_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue with search
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("deque check failed");
`define DEQS_ASSERT_NEVER(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) \
		else $error("deque forbidden condition seen");
`else
`define DEQS_ASSERT(lbl, prop)
`define DEQS_ASSERT_NEVER(lbl, prop)
`endif

`endif

FILE: src/deqs_pkg.sv
// ----------------------------------------------------------------------------
// deqs_pkg
// Shared constants and types of the double-ended queue with search.
// ----------------------------------------------------------------------------
package deqs_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ST_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_LOOKUP     = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic take;
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic lookup;
	} cell_cmd_t;

endpackage

FILE: src/deqs_cell.sv
// ----------------------------------------------------------------------------
// deqs_cell
// One storage cell of the queue chain, with its own lookup comparator.
// ----------------------------------------------------------------------------
module deqs_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  deqs_pkg::cell_cmd_t                  cmd,
	input  logic signed [deqs_pkg::DATA_W-1:0]   key,
	input  logic signed [deqs_pkg::DATA_W-1:0]   l_val,
	input  logic                                 l_vld,
	input  logic signed [deqs_pkg::DATA_W-1:0]   r_val,
	input  logic                                 r_vld,
	output logic signed [deqs_pkg::DATA_W-1:0]   val,
	output logic                                 vld,
	output logic                                 last,
	output logic                                 match
);
	import deqs_pkg::*;

	logic signed [DATA_W-1:0] val_q;
	logic                     vld_q;
	logic                     match_q;

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			val_q <= l_val;
		end else if (cmd.push_back && !vld_q && l_vld) begin
			val_q <= key;
		end else if (cmd.pop_front) begin
			val_q <= r_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				vld_q <= l_vld;
			end else if (cmd.push_back) begin
				vld_q <= vld_q | l_vld;
			end else if (cmd.pop_front) begin
				vld_q <= r_vld;
			end else if (cmd.pop_back && !r_vld) begin
				vld_q <= 1'b0;
			end
			if (cmd.take) begin
				match_q <= cmd.lookup && vld_q && (val_q == key);
			end
		end
	end

	assign val   = val_q;
	assign vld   = vld_q;
	assign last  = vld_q && !r_vld;
	assign match = match_q;

endmodule

FILE: src/double_ended_queue_with_search_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_top
// Bounded double-ended queue of signed values held in a chain of cells, with
// a comparator in every cell for membership lookup.
//
//   channel | valid     | ready     | payload
//   request | req_valid | req_ready | opcode, value
//   result  | rsp_valid | rsp_ready | removed_value, found, entry_count,
//           |           |           | is_empty, front_value, back_value, status
//
// A request updates every cell in the cycle it is accepted; its result is
// formed from the cells once the output register is free, and sits there.
// A new request is taken only after the previous one reaches the output register.
// A result stalled by rsp_ready low holds the next finished request back.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_search_top_assert.svh"

module double_ended_queue_with_search_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [deqs_pkg::OP_W-1:0]            opcode,
	input  logic signed [deqs_pkg::DATA_W-1:0]   value,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic signed [deqs_pkg::DATA_W-1:0]   removed_value,
	output logic                                 found,
	output logic [deqs_pkg::CNT_W-1:0]           entry_count,
	output logic                                 is_empty,
	output logic signed [deqs_pkg::DATA_W-1:0]   front_value,
	output logic signed [deqs_pkg::DATA_W-1:0]   back_value,
	output logic [deqs_pkg::ST_W-1:0]            status
);
	import deqs_pkg::*;

	logic signed [DATA_W-1:0] c_val [DEPTH];
	logic [DEPTH-1:0]         vld_vec;
	logic [DEPTH-1:0]         last_vec;
	logic [DEPTH-1:0]         match_vec;

	cell_cmd_t                cmd;
	op_t                      op;
	logic                     take;
	logic                     full;
	logic                     empty;
	logic                     load_out;
	status_t                  status_d;
	logic signed [DATA_W-1:0] removed_d;
	logic signed [DATA_W-1:0] front_val;
	logic signed [DATA_W-1:0] back_val;

	logic [CNT_W-1:0]         count_q;
	logic                     pend_s1;
	logic signed [DATA_W-1:0] removed_s1;
	status_t                  status_s1;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] removed_s2;
	logic                     found_s2;
	logic [CNT_W-1:0]         count_s2;
	logic                     empty_s2;
	logic signed [DATA_W-1:0] front_s2;
	logic signed [DATA_W-1:0] back_s2;
	status_t                  status_s2;

	assign op        = op_t'(opcode);
	assign req_ready = !pend_s1;
	assign take      = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign load_out  = pend_s1 && (!rsp_valid_q || rsp_ready);

	always_comb begin
		cmd            = '0;
		cmd.take       = take;
		cmd.push_front = take && (op == OP_PUSH_FRONT) && !full;
		cmd.push_back  = take && (op == OP_PUSH_BACK) && !full;
		cmd.pop_front  = take && (op == OP_POP_FRONT) && !empty;
		cmd.pop_back   = take && (op == OP_POP_BACK) && !empty;
		cmd.lookup     = take && (op == OP_LOOKUP);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] l_val;
		logic                     l_vld;
		logic signed [DATA_W-1:0] r_val;
		logic                     r_vld;

		if (i == 0) begin : g_head
			assign l_val = value;
			assign l_vld = 1'b1;
		end else begin : g_body
			assign l_val = c_val[i-1];
			assign l_vld = vld_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_inner
			assign r_val = c_val[i+1];
			assign r_vld = vld_vec[i+1];
		end

		deqs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.key    (value),
			.l_val  (l_val),
			.l_vld  (l_vld),
			.r_val  (r_val),
			.r_vld  (r_vld),
			.val    (c_val[i]),
			.vld    (vld_vec[i]),
			.last   (last_vec[i]),
			.match  (match_vec[i])
		);
	end

	always_comb begin
		back_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_val = back_val | (c_val[i] & {DATA_W{last_vec[i]}});
		end
		front_val = c_val[0] & {DATA_W{vld_vec[0]}};
	end

	always_comb begin
		unique case (op) inside
			OP_PUSH_FRONT, OP_PUSH_BACK: status_d = full ? ST_FULL : ST_OK;
			OP_POP_FRONT, OP_POP_BACK:   status_d = empty ? ST_EMPTY : ST_OK;
			default:                     status_d = ST_OK;
		endcase
	end

	always_comb begin
		if (cmd.pop_front) begin
			removed_d = front_val;
		end else if (cmd.pop_back) begin
			removed_d = back_val;
		end else begin
			removed_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.push_front || cmd.push_back) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop_front || cmd.pop_back) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (take) begin
				pend_s1 <= 1'b1;
			end else if (load_out) begin
				pend_s1 <= 1'b0;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			removed_s1 <= removed_d;
			status_s1  <= status_d;
		end
		if (load_out) begin
			removed_s2 <= removed_s1;
			found_s2   <= |match_vec;
			count_s2   <= count_q;
			empty_s2   <= (count_q == '0);
			front_s2   <= front_val;
			back_s2    <= back_val;
			status_s2  <= status_s1;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign removed_value = removed_s2;
	assign found         = found_s2;
	assign entry_count   = count_s2;
	assign is_empty      = empty_s2;
	assign front_value   = front_s2;
	assign back_value    = back_s2;
	assign status        = status_s2;

	`DEQS_ASSERT(a_count_tracks_cells, $countones(vld_vec) == int'(count_q))
	`DEQS_ASSERT(a_cells_packed, $onehot({1'b0, vld_vec} + {{DEPTH{1'b0}}, 1'b1}))
	`DEQS_ASSERT(a_match_only_lookup, $past(take && (op != OP_LOOKUP)) |-> (match_vec == '0))
	`DEQS_ASSERT_NEVER(a_found_when_empty, rsp_valid_q && found_s2 && empty_s2)
	`DEQS_ASSERT(a_full_status_count,
		(rsp_valid_q && (status_s2 == ST_FULL)) |-> (count_s2 == CNT_W'(DEPTH)))

endmodule
